>>> hw/rtl/receive_buffer_chain_reader_core_assert.svh
// ---------------------------------------------------------------------------
// Receive buffer chain reader: assertion macros
// Clocked property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef RECEIVE_BUFFER_CHAIN_READER_CORE_ASSERT_SVH
`define RECEIVE_BUFFER_CHAIN_READER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define RBCR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// cond must never be seen outside reset
`define RBCR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define RBCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBCR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> hw/rtl/rbcr_pkg.sv
// ---------------------------------------------------------------------------
// rbcr_pkg
// Field widths, request codes and the ring entry type of the reader.
// ---------------------------------------------------------------------------
package rbcr_pkg;

	localparam int ID_W     = 10;
	localparam int BYTES_W  = 13;
	localparam int REQ_W    = 18;
	localparam int ACTION_W = 2;
	localparam int KIND_W   = 2;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CONSUME = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEG = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REL = 2'd2;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BYTES_W-1:0] size;
	} ring_entry_t;

endpackage

>>> hw/rtl/receive_buffer_chain_reader_core.sv
// ---------------------------------------------------------------------------
// receive_buffer_chain_reader_core
// Ring of received buffers with read offset and readable byte total; push,
// peek and consume requests.
// ---------------------------------------------------------------------------
// A request is taken only while the sequencer is idle. A push, a refused
// request and a zero-byte peek or consume pass from the accepting cycle
// to the ACK state, which hands the single result to the output register.
// A peek or consume walks the ring one entry per cycle while the output
// register is not held by the sink, since each entry comes out of the ring
// memory through its registered read port. A consume that ends exactly on
// a buffer boundary passes through a flush state to deliver its last
// released buffer. The ring needs no clearing after reset.
// ---------------------------------------------------------------------------
module receive_buffer_chain_reader_core #(
	parameter int RING_DEPTH  = 32,
	parameter int BUFFER_SIZE = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rbcr_pkg::ACTION_W-1:0] action,
	input  logic [rbcr_pkg::ID_W-1:0]     buffer_id,
	input  logic [rbcr_pkg::BYTES_W-1:0]  buffer_bytes,
	input  logic [rbcr_pkg::REQ_W-1:0]    request_bytes,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [rbcr_pkg::KIND_W-1:0]   kind,
	output logic [rbcr_pkg::ID_W-1:0]     segment_buffer,
	output logic [rbcr_pkg::BYTES_W-1:0]  segment_offset,
	output logic [rbcr_pkg::BYTES_W-1:0]  segment_length,
	output logic [rbcr_pkg::REQ_W-1:0]    readable_total,
	output logic                          last
);

`include "receive_buffer_chain_reader_core_assert.svh"

	localparam int SLOT_W  = $clog2(RING_DEPTH);
	localparam int CNT_W   = $clog2(2 * RING_DEPTH);
	localparam int BYTES_W = rbcr_pkg::BYTES_W;
	localparam int REQ_W   = rbcr_pkg::REQ_W;
	localparam int BYTES_MAX = (1 << BYTES_W) - 1;
	localparam int SAT_INT = (BUFFER_SIZE > BYTES_MAX) ? BYTES_MAX : BUFFER_SIZE;

	localparam logic [CNT_W:0]     TWO_D   = (CNT_W + 1)'(2 * RING_DEPTH);
	localparam logic [CNT_W-1:0]   CNT_TOP = CNT_W'(2 * RING_DEPTH - 1);
	localparam logic [CNT_W-1:0]   DEPTH_C = CNT_W'(RING_DEPTH);
	localparam logic [CNT_W-1:0]   ONE_C   = CNT_W'(1);
	localparam logic [BYTES_W-1:0] SAT_BYTES = BYTES_W'(SAT_INT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK,
		ST_WALK,
		ST_FLUSH
	} state_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] s;
		s = (c >= DEPTH_C) ? (c - DEPTH_C) : c;
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_TOP) ? '0 : (c + ONE_C);
	endfunction

	state_t                          state_q;
	logic [rbcr_pkg::ACTION_W-1:0]   act_q;
	logic [REQ_W-1:0]                rem_q;
	logic [CNT_W-1:0]                left_q;
	logic                            first_q;
	logic [CNT_W-1:0]                cur_q;
	logic [CNT_W-1:0]                head_q;
	logic [CNT_W-1:0]                tail_q;
	logic [BYTES_W-1:0]              head_off_q;
	logic [REQ_W-1:0]                readable_q;
	logic                            ack_status_q;
	logic                            pend_valid_q;
	logic [rbcr_pkg::ID_W-1:0]       pend_id_q;

	logic                            out_valid_q;
	logic                            status_q;
	logic [rbcr_pkg::KIND_W-1:0]     kind_q;
	logic [rbcr_pkg::ID_W-1:0]       seg_buf_q;
	logic [BYTES_W-1:0]              seg_off_q;
	logic [BYTES_W-1:0]              seg_len_q;
	logic [REQ_W-1:0]                total_q;
	logic                            last_q;

	// ring occupancy from the wrapping counters
	logic [CNT_W:0]                  occ_diff;
	logic [CNT_W-1:0]                occ;
	logic                            ring_full;

	logic                            out_free;
	logic                            accept;
	logic [BYTES_W-1:0]              push_bytes;
	logic [CNT_W-1:0]                cur_d;

	// walk step
	rbcr_pkg::ring_entry_t           ent;
	logic [BYTES_W-1:0]              step_off;
	logic [BYTES_W-1:0]              step_avail;
	logic                            step_break;
	logic [BYTES_W-1:0]              step_len;
	logic [REQ_W-1:0]                step_rem;
	logic                            peek_last;
	logic                            rel_done;
	logic                            step;

	// result on offer to the output register
	logic                            emit_vld;
	logic                            emit_status;
	logic [rbcr_pkg::KIND_W-1:0]     emit_kind;
	logic [rbcr_pkg::ID_W-1:0]       emit_buf;
	logic [BYTES_W-1:0]              emit_off;
	logic [BYTES_W-1:0]              emit_len;
	logic                            emit_last;

	logic                            wr_en;
	rbcr_pkg::ring_entry_t           wr_data;

	assign occ_diff  = {1'b0, tail_q} + TWO_D - {1'b0, head_q};
	assign occ       = (occ_diff >= TWO_D) ? CNT_W'(occ_diff - TWO_D) : occ_diff[CNT_W-1:0];
	assign ring_full = (occ >= DEPTH_C);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign step      = (state_q == ST_WALK) && out_free;

	assign push_bytes = (buffer_bytes > SAT_BYTES) ? SAT_BYTES : buffer_bytes;

	assign wr_en        = accept && (action == rbcr_pkg::ACT_PUSH) && !ring_full;
	assign wr_data.id   = buffer_id;
	assign wr_data.size = push_bytes;

	// the read address follows the next cursor so the entry is ready next cycle
	always_comb begin
		if (state_q == ST_IDLE) begin
			cur_d = head_q;
		end else if (step) begin
			cur_d = bump(cur_q);
		end else begin
			cur_d = cur_q;
		end
	end

	rbcr_ring #(
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_slot (slot_of(tail_q)),
		.wr_data (wr_data),
		.rd_slot (slot_of(cur_d)),
		.rd_data (ent)
	);

	// a consume always reads from the head offset; a peek only on its first entry
	assign step_off   = ((act_q == rbcr_pkg::ACT_CONSUME) || first_q) ? head_off_q : '0;
	assign step_avail = (ent.size > step_off) ? (ent.size - step_off) : '0;
	assign step_break = ({{(REQ_W - BYTES_W){1'b0}}, step_avail} > rem_q);
	assign step_len   = step_break ? rem_q[BYTES_W-1:0] : step_avail;
	assign step_rem   = rem_q - {{(REQ_W - BYTES_W){1'b0}}, step_len};
	assign peek_last  = (left_q == ONE_C) || (step_rem == '0);
	assign rel_done   = (left_q == ONE_C) || (step_rem == '0);

	always_comb begin
		emit_vld    = 1'b0;
		emit_status = rbcr_pkg::STATUS_OK;
		emit_kind   = rbcr_pkg::KIND_ACK;
		emit_buf    = '0;
		emit_off    = '0;
		emit_len    = '0;
		emit_last   = 1'b1;
		case (state_q)
			ST_ACK: begin
				emit_vld    = 1'b1;
				emit_status = ack_status_q;
			end
			ST_FLUSH: begin
				emit_vld  = 1'b1;
				emit_kind = rbcr_pkg::KIND_REL;
				emit_buf  = pend_id_q;
			end
			ST_WALK: begin
				if (act_q == rbcr_pkg::ACT_PEEK) begin
					emit_vld  = 1'b1;
					emit_kind = rbcr_pkg::KIND_SEG;
					emit_buf  = ent.id;
					emit_off  = step_off;
					emit_len  = step_len;
					emit_last = peek_last;
				end else if (step_break) begin
					// consume stops inside this buffer
					emit_vld = 1'b1;
					if (pend_valid_q) begin
						emit_kind = rbcr_pkg::KIND_REL;
						emit_buf  = pend_id_q;
					end
				end else begin
					// hold the new release until the next step shows whether it is last
					emit_vld  = pend_valid_q;
					emit_kind = rbcr_pkg::KIND_REL;
					emit_buf  = pend_id_q;
					emit_last = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= rbcr_pkg::ACT_PUSH;
			rem_q        <= '0;
			left_q       <= '0;
			first_q      <= 1'b0;
			cur_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			head_off_q   <= '0;
			readable_q   <= '0;
			ack_status_q <= rbcr_pkg::STATUS_OK;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= rbcr_pkg::STATUS_OK;
			kind_q       <= rbcr_pkg::KIND_ACK;
			seg_buf_q    <= '0;
			seg_off_q    <= '0;
			seg_len_q    <= '0;
			total_q      <= '0;
			last_q       <= 1'b0;
		end else begin
			cur_q <= cur_d;

			if (emit_vld && out_free) begin
				out_valid_q <= 1'b1;
				status_q    <= emit_status;
				kind_q      <= emit_kind;
				seg_buf_q   <= emit_buf;
				seg_off_q   <= emit_off;
				seg_len_q   <= emit_len;
				total_q     <= readable_q;
				last_q      <= emit_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q <= action;
						case (action)
							rbcr_pkg::ACT_PUSH: begin
								state_q <= ST_ACK;
								if (ring_full) begin
									ack_status_q <= rbcr_pkg::STATUS_REFUSED;
								end else begin
									ack_status_q <= rbcr_pkg::STATUS_OK;
									tail_q       <= bump(tail_q);
									readable_q   <= readable_q
										+ {{(REQ_W - BYTES_W){1'b0}}, push_bytes};
								end
							end
							rbcr_pkg::ACT_PEEK, rbcr_pkg::ACT_CONSUME: begin
								if (request_bytes > readable_q) begin
									ack_status_q <= rbcr_pkg::STATUS_REFUSED;
									state_q      <= ST_ACK;
								end else if (request_bytes != '0) begin
									ack_status_q <= rbcr_pkg::STATUS_OK;
									rem_q        <= request_bytes;
									left_q       <= occ;
									first_q      <= 1'b1;
									state_q      <= ST_WALK;
									if (action == rbcr_pkg::ACT_CONSUME) begin
										readable_q <= readable_q - request_bytes;
									end
								end else begin
									ack_status_q <= rbcr_pkg::STATUS_OK;
									state_q      <= ST_ACK;
								end
							end
							default: begin
								ack_status_q <= rbcr_pkg::STATUS_REFUSED;
								state_q      <= ST_ACK;
							end
						endcase
					end
				end
				ST_ACK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (step) begin
						first_q <= 1'b0;
						left_q  <= left_q - ONE_C;
						rem_q   <= step_rem;
						if (act_q == rbcr_pkg::ACT_PEEK) begin
							if (peek_last) begin
								state_q <= ST_IDLE;
							end
						end else if (step_break) begin
							// advance the offset inside the head buffer
							head_off_q   <= step_off + rem_q[BYTES_W-1:0];
							pend_valid_q <= 1'b0;
							state_q      <= ST_IDLE;
						end else begin
							// release the head buffer
							head_q       <= bump(head_q);
							head_off_q   <= '0;
							pend_valid_q <= 1'b1;
							pend_id_q    <= ent.id;
							if (rel_done) begin
								state_q <= ST_FLUSH;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign kind           = kind_q;
	assign segment_buffer = seg_buf_q;
	assign segment_offset = seg_off_q;
	assign segment_length = seg_len_q;
	assign readable_total = total_q;
	assign last           = last_q;

	`RBCR_ASSERT(a_occ_bound, clk, arst_n, occ <= DEPTH_C, "ring occupancy above depth")
	`RBCR_ASSERT_NEVER(a_walk_left, clk, arst_n, (state_q == ST_WALK) && (left_q == '0), "ring walk past the tail")
	`RBCR_ASSERT_NEVER(a_bytes_empty, clk, arst_n, (readable_q != '0) && (occ == '0), "readable bytes with an empty ring")
	`RBCR_ASSERT(a_last_idle, clk, arst_n, (emit_vld && out_free && emit_last) |=> (state_q == ST_IDLE), "final result left the sequencer busy")
	`RBCR_ASSERT_NEVER(a_pend_peek, clk, arst_n, pend_valid_q && (act_q != rbcr_pkg::ACT_CONSUME), "held release outside a consume")

endmodule

>>> hw/rtl/rbcr_ring.sv
// ---------------------------------------------------------------------------
// rbcr_ring
// Ring store of buffer id and byte count: one write and one registered read
// per cycle.
// ---------------------------------------------------------------------------
module rbcr_ring #(
	parameter int  DEPTH  = 32,
	localparam int SLOT_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [SLOT_W-1:0]    wr_slot,
	input  rbcr_pkg::ring_entry_t wr_data,
	input  logic [SLOT_W-1:0]    rd_slot,
	output rbcr_pkg::ring_entry_t rd_data
);

	rbcr_pkg::ring_entry_t mem_q [DEPTH];
	rbcr_pkg::ring_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_slot] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_slot];
	end

	assign rd_data = rd_data_q;

endmodule
